>>> src/ple_pkg.sv
package ple_pkg;

    localparam int CAPACITY = 32;
    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int LENO_W   = 6;
    localparam int IDX_W    = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LEN_W    = $clog2(CAPACITY + 1);
    localparam int CMP_W    = (LEN_W > POS_W) ? LEN_W : POS_W;
    localparam int LENO_MAX = (1 << LENO_W) - 1;

    typedef enum logic [2:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_END   = 3'd1,
        OP_INS_POS   = 3'd2,
        OP_DEL_FRONT = 3'd3,
        OP_DEL_END   = 3'd4,
        OP_DEL_POS   = 3'd5,
        OP_READ_ALL  = 3'd6,
        OP_INVALID   = 3'd7
    } opcode_t;

    typedef enum logic [2:0] {
        ST_OK    = 3'd0,
        ST_EMPTY = 3'd1,
        ST_RANGE = 3'd2,
        ST_FULL  = 3'd3,
        ST_BADOP = 3'd4
    } status_t;

    typedef struct packed {
        opcode_t                   opcode;
        logic signed [DATA_W-1:0]  item_value;
        logic        [POS_W-1:0]   position;
    } in_item_t;

    typedef struct packed {
        logic signed [DATA_W-1:0]  element_value;
        logic                      has_element;
        status_t                   status;
        logic        [LENO_W-1:0]  length_after;
        logic                      last;
    } out_item_t;

    // length field saturates when the store can hold more than it shows
    function automatic logic [LENO_W-1:0] sat_len(input logic [LEN_W-1:0] len);
        logic [LENO_W-1:0] res;
        if (32'(len) > 32'(LENO_MAX)) begin
            res = LENO_W'(LENO_MAX);
        end else begin
            res = LENO_W'(len);
        end
        return res;
    endfunction

endpackage

>>> src/positional_list_engine_top.sv
// Bounded ordered list of signed 32-bit values, up to CAPACITY entries.
// Input channel (s_valid/s_ready/s_item) takes one command transaction:
// insert front/end/at position, delete front/end/at position, read all.
// Result channel (m_valid/m_ready/m_item) returns one transaction per
// command, or one per element for read-all (the final one has last set;
// an empty list reads out as a single transaction with has_element low).
// Commands are handled one at a time by a small sequencer around a
// single-port-write list store; s_ready is high only while it is idle.
// Rejected commands, invalid opcodes and an empty read-all go straight to
// the response state; an insert or delete first shifts the entries between
// the target position and the list end, each by a registered read, then a
// write; read-all fetches each element with a registered read before output.
// A result register sits on the output, so the next command can be
// accepted while the previous result waits for m_ready.
// Reset (aresetn low, synchronous) empties the list and drops any pending
// result; store contents are not cleared. A stalled receiver holds the
// sequencer on its current result until m_ready returns.
module positional_list_engine_top (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  ple_pkg::in_item_t  s_item,
    output logic               m_valid,
    input  logic               m_ready,
    output ple_pkg::out_item_t m_item
);
    import ple_pkg::*;

    logic      res_valid;
    logic      res_ready;
    out_item_t res_item;

    logic      m_valid_reg, m_valid_next;
    out_item_t m_item_reg;

    ple_core u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_item    (s_item),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res_item  (res_item)
    );

    assign res_ready = !m_valid_reg || m_ready;

    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_ready) begin
            m_valid_next = res_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid && res_ready) begin
            m_item_reg <= res_item;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_item  = m_item_reg;

endmodule

>>> src/ple_core.sv
module ple_core (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ple_pkg::in_item_t s_item,
    output logic              res_valid,
    input  logic              res_ready,
    output ple_pkg::out_item_t res_item
);
    import ple_pkg::*;

    typedef enum logic [7:0] {
        S_IDLE    = 8'b0000_0001,
        S_INS_RD  = 8'b0000_0010,
        S_INS_WR  = 8'b0000_0100,
        S_DEL_RD  = 8'b0000_1000,
        S_DEL_WR  = 8'b0001_0000,
        S_RD_ADDR = 8'b0010_0000,
        S_RD_OUT  = 8'b0100_0000,
        S_RESP    = 8'b1000_0000
    } state_t;

    state_t                   state_reg, state_next;
    logic [LEN_W-1:0]         len_reg, len_next;
    logic [IDX_W-1:0]         idx_reg, idx_next;
    logic [IDX_W-1:0]         pos_reg, pos_next;
    logic [DATA_W-1:0]        val_reg, val_next;
    status_t                  status_reg, status_next;
    logic [DATA_W-1:0]        rd_data_reg;

    logic [DATA_W-1:0]        mem [CAPACITY];

    logic                     wr_en;
    logic [IDX_W-1:0]         wr_addr;
    logic [DATA_W-1:0]        wr_data;
    logic [IDX_W-1:0]         rd_addr;

    logic [CMP_W-1:0]         len_c;
    logic [CMP_W-1:0]         pos_c;
    logic [CMP_W-1:0]         ins_tgt;
    logic [CMP_W-1:0]         del_tgt;
    logic [LEN_W-1:0]         idx_inc;
    logic                     rd_last;

    assign s_ready = (state_reg == S_IDLE);
    assign len_c   = CMP_W'(len_reg);
    assign pos_c   = CMP_W'(s_item.position);
    assign idx_inc = LEN_W'(idx_reg) + LEN_W'(1);
    assign rd_last = (idx_inc == len_reg);

    always_comb begin
        case (s_item.opcode)
            OP_INS_FRONT: ins_tgt = '0;
            OP_INS_END:   ins_tgt = len_c;
            default:      ins_tgt = pos_c;
        endcase
        case (s_item.opcode)
            OP_DEL_FRONT: del_tgt = '0;
            OP_DEL_END:   del_tgt = len_c - CMP_W'(1);
            default:      del_tgt = pos_c;
        endcase
    end

    always_comb begin
        state_next  = state_reg;
        len_next    = len_reg;
        idx_next    = idx_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        status_next = status_reg;
        wr_en       = 1'b0;
        wr_addr     = idx_reg;
        wr_data     = rd_data_reg;
        rd_addr     = idx_reg;
        res_valid   = 1'b0;
        res_item    = '{element_value: '0, has_element: 1'b0, status: status_reg,
                        length_after: sat_len(len_reg), last: 1'b1};

        case (state_reg)
            S_IDLE: begin
                if (s_valid) begin
                    val_next    = s_item.item_value;
                    status_next = ST_OK;
                    state_next  = S_RESP;
                    case (s_item.opcode)
                        OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
                            if (len_reg == LEN_W'(CAPACITY)) begin
                                status_next = ST_FULL;
                            end else if (ins_tgt > len_c) begin
                                status_next = ST_RANGE;
                            end else begin
                                idx_next   = IDX_W'(len_reg);
                                pos_next   = IDX_W'(ins_tgt);
                                state_next = S_INS_RD;
                            end
                        end
                        OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
                            if (len_reg == '0) begin
                                status_next = ST_EMPTY;
                            end else if (del_tgt >= len_c) begin
                                status_next = ST_RANGE;
                            end else begin
                                idx_next   = IDX_W'(del_tgt);
                                state_next = S_DEL_RD;
                            end
                        end
                        OP_READ_ALL: begin
                            // empty list still gives one result, no element
                            if (len_reg != '0) begin
                                idx_next   = '0;
                                state_next = S_RD_ADDR;
                            end
                        end
                        default: begin
                            status_next = ST_BADOP;
                        end
                    endcase
                end
            end
            S_INS_RD: begin
                if (idx_reg == pos_reg) begin
                    wr_en      = 1'b1;
                    wr_data    = val_reg;
                    len_next   = len_reg + LEN_W'(1);
                    state_next = S_RESP;
                end else begin
                    rd_addr    = idx_reg - IDX_W'(1);
                    state_next = S_INS_WR;
                end
            end
            S_INS_WR: begin
                wr_en      = 1'b1;
                idx_next   = idx_reg - IDX_W'(1);
                state_next = S_INS_RD;
            end
            S_DEL_RD: begin
                if (rd_last) begin
                    len_next   = len_reg - LEN_W'(1);
                    state_next = S_RESP;
                end else begin
                    rd_addr    = IDX_W'(idx_inc);
                    state_next = S_DEL_WR;
                end
            end
            S_DEL_WR: begin
                wr_en      = 1'b1;
                idx_next   = IDX_W'(idx_inc);
                state_next = S_DEL_RD;
            end
            S_RD_ADDR: begin
                state_next = S_RD_OUT;
            end
            S_RD_OUT: begin
                // read address held at idx, so rd_data stays put during a stall
                res_valid = 1'b1;
                res_item  = '{element_value: rd_data_reg, has_element: 1'b1,
                              status: ST_OK, length_after: sat_len(len_reg),
                              last: rd_last};
                if (res_ready) begin
                    if (rd_last) begin
                        state_next = S_IDLE;
                    end else begin
                        idx_next   = IDX_W'(idx_inc);
                        state_next = S_RD_ADDR;
                    end
                end
            end
            S_RESP: begin
                res_valid = 1'b1;
                if (res_ready) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= S_IDLE;
            len_reg    <= '0;
        end else begin
            state_reg  <= state_next;
            len_reg    <= len_next;
        end
    end

    always_ff @(posedge aclk) begin
        idx_reg    <= idx_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        status_reg <= status_next;
    end

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    a_len_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(len_reg) <= CAPACITY)
        else $error("list length above capacity");

    a_ins_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_INS_RD || state_reg == S_INS_WR) |-> idx_reg >= pos_reg)
        else $error("insert shift walked past target position");

    a_del_walk: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_DEL_RD || state_reg == S_DEL_WR) |-> LEN_W'(idx_reg) < len_reg)
        else $error("delete shift index beyond list end");

    a_len_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != S_INS_RD && state_reg != S_DEL_RD) |=> $stable(len_reg))
        else $error("length changed outside an insert or delete");

endmodule

>>> tb/list_checker.sv
module list_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  ple_pkg::in_item_t  s_item,
    input  logic               m_valid,
    input  logic               m_ready,
    input  ple_pkg::out_item_t m_item,
    output int                 errors,
    output int                 pending,
    output int                 list_len
);
    import ple_pkg::*;

    logic signed [DATA_W-1:0] list_copy[$];
    out_item_t                pending_results[$];

    initial begin
        errors   = 0;
        pending  = 0;
        list_len = 0;
    end

    function automatic logic [LENO_W-1:0] shown_length();
        int unsigned n;
        n = list_copy.size();
        return (n > LENO_MAX) ? LENO_W'(LENO_MAX) : LENO_W'(n);
    endfunction

    function automatic out_item_t make_result(input logic signed [DATA_W-1:0] val,
                                              input logic has, input status_t st,
                                              input logic fin);
        out_item_t r;
        r.element_value = val;
        r.has_element   = has;
        r.status        = st;
        r.length_after  = shown_length();
        r.last          = fin;
        return r;
    endfunction

    // work out the results of one accepted command and update the list copy
    task automatic apply_command(input in_item_t cmd);
        status_t     st;
        int unsigned len;
        int unsigned pos;
        len = list_copy.size();
        pos = cmd.position;
        st  = ST_OK;
        case (cmd.opcode)
            OP_INS_FRONT, OP_INS_END, OP_INS_POS: begin
                if (cmd.opcode == OP_INS_FRONT) begin
                    pos = 0;
                end else if (cmd.opcode == OP_INS_END) begin
                    pos = len;
                end
                // full is reported ahead of a bad position
                if (len >= CAPACITY) begin
                    st = ST_FULL;
                end else if (pos > len) begin
                    st = ST_RANGE;
                end else begin
                    list_copy.insert(pos, cmd.item_value);
                end
            end
            OP_DEL_FRONT, OP_DEL_END, OP_DEL_POS: begin
                if (cmd.opcode == OP_DEL_FRONT) begin
                    pos = 0;
                end else if (cmd.opcode == OP_DEL_END) begin
                    pos = (len == 0) ? 0 : len - 1;
                end
                if (len == 0) begin
                    st = ST_EMPTY;
                end else if (pos >= len) begin
                    st = ST_RANGE;
                end else begin
                    list_copy.delete(pos);
                end
            end
            OP_READ_ALL: begin
                st = ST_OK;
            end
            default: begin
                st = ST_BADOP;
            end
        endcase

        if (cmd.opcode == OP_READ_ALL && len != 0) begin
            for (int i = 0; i < len; i++) begin
                pending_results.push_back(make_result(list_copy[i], 1'b1, ST_OK,
                                                      i == len - 1));
            end
        end else begin
            pending_results.push_back(make_result('0, 1'b0, st, 1'b1));
        end
    endtask

    function automatic void note_mismatch(input string field, input longint want,
                                          input longint got);
        $display("%0t: %s mismatch: expected %0d, got %0d", $time, field, want, got);
        errors++;
    endfunction

    task automatic check_result(input out_item_t got);
        out_item_t want;
        if (pending_results.size() == 0) begin
            $display("%0t: unexpected result transaction: expected none, got %h",
                     $time, got);
            errors++;
        end else begin
            want = pending_results.pop_front();
            if (got.element_value !== want.element_value)
                note_mismatch("element_value", want.element_value, got.element_value);
            if (got.has_element !== want.has_element)
                note_mismatch("has_element", want.has_element, got.has_element);
            if (got.status !== want.status)
                note_mismatch("status", want.status, got.status);
            if (got.length_after !== want.length_after)
                note_mismatch("length_after", want.length_after, got.length_after);
            if (got.last !== want.last)
                note_mismatch("last", want.last, got.last);
        end
    endtask

    always @(posedge aclk) begin
        if (!aresetn) begin
            list_copy.delete();
            pending_results.delete();
        end else begin
            if (m_valid && m_ready) begin
                check_result(m_item);
            end
            if (s_valid && s_ready) begin
                apply_command(s_item);
            end
        end
        pending  <= pending_results.size();
        list_len <= list_copy.size();
    end

endmodule

>>> tb/tb.sv
module tb;
    import ple_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 100;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_item  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_item;

    int errors;
    int pending;
    int list_len;
    int cycles        = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int hold_left     = 0;
    logic hold_req    = 1'b0;
    logic hold_done   = 1'b0;

    always #10 aclk = ~aclk;

    positional_list_engine_top dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_item  (s_item),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_item  (m_item)
    );

    list_checker u_checker (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_item   (s_item),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_item   (m_item),
        .errors   (errors),
        .pending  (pending),
        .list_len (list_len)
    );

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_req && !hold_done) begin
            m_ready   <= 1'b0;
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("FAIL positional_list_engine_top");
            $finish;
        end
    end

    function automatic in_item_t cmd(input opcode_t op, input logic [DATA_W-1:0] val,
                                     input int unsigned pos);
        in_item_t c;
        c.opcode     = op;
        c.item_value = val;
        c.position   = POS_W'(pos);
        return c;
    endfunction

    // mode 0 leans to inserts, 1 to deletes, 2 is balanced
    function automatic in_item_t random_cmd(input int mode, input int unsigned len);
        int unsigned r;
        int unsigned ins_w;
        int unsigned del_w;
        int unsigned pos;
        opcode_t     op;
        ins_w = (mode == 0) ? 65 : (mode == 1) ? 20 : 40;
        del_w = (mode == 1) ? 65 : (mode == 0) ? 20 : 40;
        r = $urandom_range(0, 99);
        if (r < ins_w) begin
            case ($urandom_range(0, 2))
                0:       op = OP_INS_FRONT;
                1:       op = OP_INS_END;
                default: op = OP_INS_POS;
            endcase
            pos = $urandom_range(0, len);
        end else if (r < ins_w + del_w) begin
            case ($urandom_range(0, 2))
                0:       op = OP_DEL_FRONT;
                1:       op = OP_DEL_END;
                default: op = OP_DEL_POS;
            endcase
            pos = $urandom_range(0, (len == 0) ? 0 : len - 1);
        end else if (r < 95) begin
            op  = OP_READ_ALL;
            pos = $urandom_range(0, 63);
        end else begin
            op  = opcode_t'($urandom_range(0, 7));
            pos = $urandom_range(0, 63);
        end
        // some positions anywhere in the field, mostly out of range
        if ($urandom_range(0, 99) < 25) begin
            pos = $urandom_range(0, 63);
        end
        return cmd(op, $urandom, pos);
    endfunction

    task automatic send_cmd(input in_item_t c);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_item  <= c;
        do @(posedge aclk); while (!s_ready);
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending != 0) @(posedge aclk);
    endtask

    task automatic random_phase(input int send_pct, input int recv_pct,
                                input logic with_hold);
        int mode;
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
        for (int blk = 0; blk < 10; blk++) begin
            if (with_hold && blk == 3) begin
                hold_req <= 1'b1;
            end
            mode = $urandom_range(0, 2);
            repeat (16) send_cmd(random_cmd(mode, list_len));
        end
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        send_idle_pct = 7;
        recv_idle_pct <= 68;

        // empty list corners
        send_cmd(cmd(OP_READ_ALL,  32'h0, 0));
        send_cmd(cmd(OP_DEL_FRONT, 32'h0, 0));
        send_cmd(cmd(OP_DEL_END,   32'h0, 0));
        send_cmd(cmd(OP_DEL_POS,   32'h0, 0));
        send_cmd(cmd(OP_INVALID,   32'hFFFF_FFFF, 63));
        send_cmd(cmd(OP_INS_POS,   32'h1234_5678, 1));
        // build a short list with extreme values
        send_cmd(cmd(OP_INS_POS,   32'h7FFF_FFFF, 0));
        send_cmd(cmd(OP_INS_FRONT, 32'h8000_0000, 0));
        send_cmd(cmd(OP_INS_END,   32'hFFFF_FFFF, 0));
        send_cmd(cmd(OP_INS_POS,   32'h0, 3));
        send_cmd(cmd(OP_INS_POS,   32'h1, 63));
        send_cmd(cmd(OP_INS_POS,   32'h5555_5555, 2));
        send_cmd(cmd(OP_INS_POS,   32'hAAAA_AAAA, 1));
        send_cmd(cmd(OP_READ_ALL,  32'h0, 0));
        // deletes in and out of range
        send_cmd(cmd(OP_DEL_POS,   32'h0, 63));
        send_cmd(cmd(OP_DEL_POS,   32'h0, 6));
        send_cmd(cmd(OP_DEL_POS,   32'h0, 2));
        send_cmd(cmd(OP_DEL_END,   32'h0, 0));
        send_cmd(cmd(OP_DEL_FRONT, 32'h0, 0));
        send_cmd(cmd(OP_READ_ALL,  32'h0, 0));
        send_cmd(cmd(OP_INVALID,   32'h0, 0));
        wait_drained();

        // fill to capacity, then inserts into a full list and a full read-out
        repeat (CAPACITY) send_cmd(cmd(OP_INS_END, $urandom, 0));
        send_cmd(cmd(OP_INS_FRONT, $urandom, 0));
        send_cmd(cmd(OP_INS_POS,   $urandom, 63));
        send_cmd(cmd(OP_INS_END,   $urandom, 0));
        send_cmd(cmd(OP_READ_ALL,  32'h0, 0));
        send_cmd(cmd(OP_DEL_POS,   32'h0, CAPACITY - 1));
        send_cmd(cmd(OP_DEL_POS,   32'h0, CAPACITY - 1));
        wait_drained();

        random_phase(7, 68, 1'b0);
        random_phase(68, 7, 1'b0);
        random_phase(0, 0, 1'b1);

        repeat (SETTLE) @(posedge aclk);
        if (errors == 0) begin
            $display("PASS positional_list_engine_top");
        end else begin
            $display("FAIL positional_list_engine_top");
        end
        $finish;
    end

endmodule
